FILE: rtl/b64_pkg.sv
// Shared types, constants and the character lookup of the base64 encoder.
`default_nettype none

package b64_pkg;

    // Characters emitted for each three-byte group, padding included
    localparam int unsigned GROUP_CHARS = 4;
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam logic [7:0]  PAD_CHAR    = 8'h3D;

    // One completed group as handed from the front end to the back end
    typedef struct packed {
        logic [23:0] word;      // first byte in bits 23..16
        logic [1:0]  pad_count; // trailing '=' characters, 0..2
        logic        fin;       // group closes the stream
    } group_t;

    // Standard alphabet: A-Z, a-z, 0-9, '+', '/'
    function automatic logic [7:0] sextet_to_char(input logic [5:0] sextet);
        logic [7:0] v;
        v = {2'b00, sextet};
        if (sextet < 6'd26) begin
            sextet_to_char = 8'h41 + v;
        end else if (sextet < 6'd52) begin
            sextet_to_char = 8'h61 + v - 8'd26;
        end else if (sextet < 6'd62) begin
            sextet_to_char = 8'h30 + v - 8'd52;
        end else if (sextet == 6'd62) begin
            sextet_to_char = 8'h2B;
        end else begin
            sextet_to_char = 8'h2F;
        end
    endfunction

endpackage

`default_nettype wire

FILE: rtl/base64_encoder.sv
// Top level of the streaming base64 encoder (standard alphabet, '=' padding).
//
// Input channel s_*: one raw byte per item in s_tdata; s_tlast marks the last
// byte of a stream. Output channel m_*: one ASCII character per item in
// m_tdata; m_tlast marks the last character of a group, m_tuser the last
// character of the whole stream.
// Every three bytes, or the stream's final byte, yield four characters: a
// short stream tail is padded with "=" or "==".
// A group's first character passes from the group queue through the back
// end's group register to the output register. Characters leave one per
// cycle while m_tready is high and groups are queued, so the character
// serializer sets the rate. Bytes are taken every cycle while the group
// queue (QUEUE_DEPTH groups) has room.
// When m_tready is low the current character holds in the output register;
// the back end stops, the queue fills, and s_tready then drops.
// Reset (aresetn low, synchronous) drops any partial group, empties the queue
// and clears the output valid; the next byte starts a new group.
`default_nettype none

module base64_encoder #(
    parameter int unsigned QUEUE_DEPTH = b64_pkg::QUEUE_DEPTH
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] data_byte
    input  wire logic       s_tlast,   // final_byte
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_char
    output logic            m_tlast,   // group_last
    output logic            m_tuser    // [0] stream_last
);

    logic            push, pop, queue_full, queue_empty;
    b64_pkg::group_t push_group, pop_group;

    b64_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_byte    (s_tdata),
        .in_fin     (s_tlast),
        .queue_full (queue_full),
        .push       (push),
        .push_group (push_group)
    );

    b64_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_group (push_group),
        .full       (queue_full),
        .pop        (pop),
        .pop_group  (pop_group),
        .empty      (queue_empty)
    );

    b64_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .queue_empty     (queue_empty),
        .queue_group     (pop_group),
        .pop             (pop),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_char        (m_tdata),
        .out_group_last  (m_tlast),
        .out_stream_last (m_tuser)
    );

endmodule

`default_nettype wire

FILE: rtl/b64_front.sv
// Front end: gathers input bytes into three-byte groups and closes partial groups.
`default_nettype none

module b64_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [7:0]        in_byte,
    input  wire logic              in_fin,
    input  wire logic              queue_full,
    output logic                   push,
    output b64_pkg::group_t        push_group
);

    logic [15:0] held_reg, held_next;
    logic [1:0]  pos_reg, pos_next;
    logic        accept;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    // Group assembly; position 3 never occurs and is handled like 0
    always_comb begin
        held_next  = held_reg;
        pos_next   = pos_reg;
        push       = 1'b0;
        push_group = '0;
        case (pos_reg)
            2'd1: begin
                push_group.word      = {held_reg[15:8], in_byte, 8'h00};
                push_group.pad_count = 2'd1;
                push_group.fin       = 1'b1;
                if (accept) begin
                    if (in_fin) begin
                        push     = 1'b1;
                        pos_next = 2'd0;
                    end else begin
                        held_next = {held_reg[15:8], in_byte};
                        pos_next  = 2'd2;
                    end
                end
            end
            2'd2: begin
                push_group.word      = {held_reg, in_byte};
                push_group.pad_count = 2'd0;
                push_group.fin       = in_fin;
                if (accept) begin
                    push     = 1'b1;
                    pos_next = 2'd0;
                end
            end
            default: begin
                push_group.word      = {in_byte, 16'h0000};
                push_group.pad_count = 2'd2;
                push_group.fin       = 1'b1;
                if (accept) begin
                    if (in_fin) begin
                        push     = 1'b1;
                        pos_next = 2'd0;
                    end else begin
                        held_next = {in_byte, 8'h00};
                        pos_next  = 2'd1;
                    end
                end
            end
        endcase
    end

    // Position is control state; held bytes are payload
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= 2'd0;
        end else begin
            pos_reg <= pos_next;
        end
        held_reg <= held_next;
    end

endmodule

`default_nettype wire

FILE: rtl/b64_queue.sv
// Short group queue between the front end and the character back end.
`default_nettype none

module b64_queue #(
    parameter int unsigned DEPTH = b64_pkg::QUEUE_DEPTH
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire b64_pkg::group_t   push_group,
    output logic                   full,
    input  wire logic              pop,
    output b64_pkg::group_t        pop_group,
    output logic                   empty
);

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

    b64_pkg::group_t entry_reg [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CntW-1:0] count_reg;
    logic            do_push, do_pop;

    assign full      = (count_reg == CntFull);
    assign empty     = (count_reg == '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign pop_group = entry_reg[rd_ptr_reg];

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PtrLast) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PtrLast) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_group;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CntFull)
        else $error("group queue count beyond depth");

    a_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        full && !pop |=> $stable(count_reg))
        else $error("group queue count moved while full and not drained");

    a_pop_lowers: assert property (@(posedge aclk) disable iff (!aresetn)
        do_pop && !do_push |=> count_reg == $past(count_reg) - 1'b1)
        else $error("group queue count not lowered on pop");

endmodule

`default_nettype wire

FILE: rtl/b64_back.sv
// Back end: turns each queued group into four characters, one item per cycle while out_ready is high.
`default_nettype none

module b64_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              queue_empty,
    input  wire b64_pkg::group_t   queue_group,
    output logic                   pop,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [7:0]             out_char,
    output logic                   out_group_last,
    output logic                   out_stream_last
);

    b64_pkg::group_t group_reg;
    logic            busy_reg;
    logic [1:0]      idx_reg;
    logic            valid_reg;
    logic [7:0]      char_reg;
    logic            glast_reg, slast_reg;

    logic            load;
    logic            last_char;
    logic [4:0]      shift;
    logic [5:0]      sextet;
    logic            is_pad;
    logic [7:0]      char_next;

    assign load      = busy_reg && (!valid_reg || out_ready);
    assign last_char = (idx_reg == 2'(b64_pkg::GROUP_CHARS - 1));
    assign pop       = !queue_empty && (!busy_reg || (load && last_char));

    // Slice selection, most significant sextet first
    always_comb begin
        shift     = 5'd18 - 5'({idx_reg, 1'b0} + {1'b0, idx_reg, 2'b00} >> 0);
        sextet    = 6'(group_reg.word >> shift);
        is_pad    = ({1'b0, idx_reg} >= 3'(3'd4 - {1'b0, group_reg.pad_count}));
        char_next = is_pad ? b64_pkg::PAD_CHAR : b64_pkg::sextet_to_char(sextet);
    end

    // Group holding register and character counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= 2'd0;
        end else begin
            if (pop) begin
                busy_reg <= 1'b1;
            end else if (load && last_char) begin
                busy_reg <= 1'b0;
            end
            if (load) begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
        if (pop) begin
            group_reg <= queue_group;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
        if (load) begin
            char_reg  <= char_next;
            glast_reg <= last_char;
            slast_reg <= last_char && group_reg.fin;
        end
    end

    assign out_valid       = valid_reg;
    assign out_char        = char_reg;
    assign out_group_last  = glast_reg;
    assign out_stream_last = slast_reg;

    a_stream_last_ends_group: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && slast_reg |-> glast_reg)
        else $error("stream end flagged inside a group");

    a_idle_counter_home: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |-> idx_reg == 2'd0)
        else $error("character counter off zero while idle");

    a_group_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && out_ready && !glast_reg |=> valid_reg)
        else $error("gap inside a character group");

endmodule

`default_nettype wire
